/* src/eci_pkg.sv */
// ----------------------------------------------------------------------------
// eci_pkg
// Shared widths, opcodes, status codes and the decoded item type of the
// 8-bit instruction executor.
// ----------------------------------------------------------------------------
`default_nettype none

package eci_pkg;

  // field widths
  localparam int WORD_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int REG_NUM_W = 4;
  localparam int STATUS_W  = 2;

  // item kind on the input channel
  localparam logic ITEM_EXEC    = 1'b0;
  localparam logic ITEM_PRELOAD = 1'b1;

  // opcodes, top four bits of the instruction word
  localparam logic [3:0] OPC_ADD   = 4'd0;
  localparam logic [3:0] OPC_SUB   = 4'd1;
  localparam logic [3:0] OPC_MUL   = 4'd2;
  localparam logic [3:0] OPC_INC   = 4'd3;
  localparam logic [3:0] OPC_AND   = 4'd4;
  localparam logic [3:0] OPC_OR    = 4'd5;
  localparam logic [3:0] OPC_NOT   = 4'd6;
  localparam logic [3:0] OPC_XOR   = 4'd7;
  localparam logic [3:0] OPC_LOAD  = 4'd8;
  localparam logic [3:0] OPC_STORE = 4'd9;
  localparam logic [3:0] OPC_JMP   = 4'd10;
  localparam logic [3:0] OPC_BEQZ  = 4'd11;
  localparam logic [3:0] OPC_HLT   = 4'd15;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HALTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  // class of a decoded item
  typedef enum logic [2:0] {
    K_PRELOAD,
    K_ALU,
    K_LOAD,
    K_STORE,
    K_JMP,
    K_BEQZ,
    K_HLT,
    K_BAD
  } kind_t;

  // decoded item passed from front to back
  typedef struct packed {
    kind_t                kind;
    logic [3:0]           opc;
    logic [REG_NUM_W-1:0] ra;
    logic [REG_NUM_W-1:0] rb;
    logic [REG_NUM_W-1:0] rc;
    logic                 port2_ra;
    logic [BYTE_W-1:0]    offset;
    logic [BYTE_W-1:0]    mem_address;
    logic [BYTE_W-1:0]    mem_value;
  } uop_t;

endpackage

`default_nettype wire

/* src/eci_in_if.sv */
// ----------------------------------------------------------------------------
// eci_in_if
// Input channel: instruction words and data memory preload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface eci_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [eci_pkg::WORD_W-1:0]  instruction;
  logic [eci_pkg::BYTE_W-1:0]  mem_address;
  logic [eci_pkg::BYTE_W-1:0]  mem_value;

  modport source (
    output valid, op, instruction, mem_address, mem_value,
    input  ready
  );

  modport sink (
    input  valid, op, instruction, mem_address, mem_value,
    output ready
  );
endinterface

`default_nettype wire

/* src/eci_out_if.sv */
// ----------------------------------------------------------------------------
// eci_out_if
// Result channel: pc after the item, register write and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface eci_out_if;
  logic                           valid;
  logic                           ready;
  logic [eci_pkg::BYTE_W-1:0]     next_pc;
  logic                           reg_written;
  logic [eci_pkg::REG_NUM_W-1:0]  dest_reg;
  logic [eci_pkg::BYTE_W-1:0]     write_value;
  logic [eci_pkg::STATUS_W-1:0]   status;

  modport source (
    output valid, next_pc, reg_written, dest_reg, write_value, status,
    input  ready
  );

  modport sink (
    input  valid, next_pc, reg_written, dest_reg, write_value, status,
    output ready
  );
endinterface

`default_nettype wire

/* src/eci_front.sv */
// ----------------------------------------------------------------------------
// eci_front
// Accepts input items and classifies them into decoded items for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module eci_front (
  eci_in_if.sink        req,
  output logic          uop_valid,
  input  logic          uop_ready,
  output eci_pkg::uop_t uop
);

  logic [3:0] opc;

  assign opc       = req.instruction[15:12];
  assign uop_valid = req.valid;
  assign req.ready = uop_ready;

  // field split and classification
  always_comb begin
    uop.opc         = opc;
    uop.ra          = req.instruction[11:8];
    uop.rb          = req.instruction[7:4];
    uop.rc          = req.instruction[3:0];
    uop.mem_address = req.mem_address;
    uop.mem_value   = req.mem_value;
    uop.port2_ra    = (opc == eci_pkg::OPC_INC) || (opc == eci_pkg::OPC_STORE) ||
                      (opc == eci_pkg::OPC_BEQZ);
    uop.offset      = (opc == eci_pkg::OPC_JMP) ? req.instruction[11:4]
                                                : req.instruction[7:0];
    if (req.op == eci_pkg::ITEM_PRELOAD) begin
      uop.kind = eci_pkg::K_PRELOAD;
    end else begin
      unique case (opc)
        eci_pkg::OPC_ADD, eci_pkg::OPC_SUB, eci_pkg::OPC_MUL, eci_pkg::OPC_INC,
        eci_pkg::OPC_AND, eci_pkg::OPC_OR, eci_pkg::OPC_NOT,
        eci_pkg::OPC_XOR:   uop.kind = eci_pkg::K_ALU;
        eci_pkg::OPC_LOAD:  uop.kind = eci_pkg::K_LOAD;
        eci_pkg::OPC_STORE: uop.kind = eci_pkg::K_STORE;
        eci_pkg::OPC_JMP:   uop.kind = eci_pkg::K_JMP;
        eci_pkg::OPC_BEQZ:  uop.kind = eci_pkg::K_BEQZ;
        eci_pkg::OPC_HLT:   uop.kind = eci_pkg::K_HLT;
        default:            uop.kind = eci_pkg::K_BAD;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/eci_queue.sv */
// ----------------------------------------------------------------------------
// eci_queue
// Two-entry queue of decoded items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module eci_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  eci_pkg::uop_t push_uop,
  output logic          pop_valid,
  input  logic          pop_ready,
  output eci_pkg::uop_t pop_uop
);

  localparam logic [1:0] QDEPTH = 2'd2;

  eci_pkg::uop_t ent [2];
  logic [1:0]    count;
  logic          wp;
  logic          rp;
  logic          push;
  logic          pop;

  assign push_ready = (count != QDEPTH);
  assign pop_valid  = (count != 2'd0);
  assign pop_uop    = ent[rp];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) ent[wp] <= push_uop;
  end

endmodule

`default_nettype wire

/* src/eci_back.sv */
// ----------------------------------------------------------------------------
// eci_back
// Executes decoded items in order: register read, execute with data memory
// access, and a result register that also finishes loads.
// ----------------------------------------------------------------------------
`default_nettype none

module eci_back #(
  parameter int NUM_REGS       = 16,
  parameter int DATA_MEM_BYTES = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          uop_valid,
  output logic          uop_ready,
  input  eci_pkg::uop_t uop,
  eci_out_if.source     rsp
);

  localparam int RIW = $clog2(NUM_REGS);
  localparam int MIW = $clog2(DATA_MEM_BYTES);
  localparam logic [eci_pkg::REG_NUM_W:0] NREG  = (eci_pkg::REG_NUM_W + 1)'(NUM_REGS);
  localparam logic [eci_pkg::BYTE_W:0]    NBYTE = (eci_pkg::BYTE_W + 1)'(DATA_MEM_BYTES);

  // architectural state
  logic [7:0]                regs [NUM_REGS];
  logic [7:0]                dmem [DATA_MEM_BYTES];
  logic [DATA_MEM_BYTES-1:0] dvalid;
  logic [7:0]                pc;
  logic                      halted;

  // register file write port
  logic       rf_we;
  logic [3:0] rf_wa;
  logic [7:0] rf_wd;

  // read ports
  logic [3:0] rd1_addr;
  logic [3:0] rd2_addr;
  logic [7:0] rd1;
  logic [7:0] rd2;

  // execute stage
  logic          x_valid;
  eci_pkg::uop_t x_uop;
  logic [7:0]    x_a;
  logic [7:0]    x_b;
  logic          x_fire;
  logic          issue;
  logic          ld_block;
  logic [7:0]    pc2;
  logic [7:0]    br_target;
  logic [7:0]    ea;
  logic [15:0]   prod;
  logic [7:0]    alu_val;
  logic [7:0]    x_npc;
  logic [1:0]    x_status;
  logic          x_wr;
  logic          x_load;
  logic          x_ra_ok;
  logic          halt_set;
  logic          mem_we;
  logic          mem_re;
  logic [7:0]    mem_addr;
  logic [7:0]    mem_wd;
  logic          mem_ok;

  // result stage
  logic       w_valid;
  logic [7:0] w_npc;
  logic       w_wr;
  logic [3:0] w_dest;
  logic [7:0] w_val;
  logic [1:0] w_status;
  logic       w_load;
  logic [7:0] ld_data;
  logic       ld_vld;
  logic [7:0] w_value;
  logic       out_fire;

  assign out_fire = rsp.valid && rsp.ready;
  assign x_fire   = x_valid && (!w_valid || out_fire);

  // a load holds issue until its byte reaches the register file
  assign ld_block  = (x_valid && (x_uop.kind == eci_pkg::K_LOAD)) ||
                     (w_valid && w_load && !out_fire);
  assign uop_ready = (!x_valid || x_fire) && !ld_block;
  assign issue     = uop_valid && uop_ready;

  // register reads with write-through of this cycle's write
  assign rd1_addr = uop.rb;
  assign rd2_addr = uop.port2_ra ? uop.ra : uop.rc;

  always_comb begin
    rd1 = 8'd0;
    rd2 = 8'd0;
    if ({1'b0, rd1_addr} < NREG) rd1 = regs[rd1_addr[RIW-1:0]];
    if ({1'b0, rd2_addr} < NREG) rd2 = regs[rd2_addr[RIW-1:0]];
    if (rf_we && (rf_wa == rd1_addr)) rd1 = rf_wd;
    if (rf_we && (rf_wa == rd2_addr)) rd2 = rf_wd;
  end

  // execute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
    end else if (issue) begin
      x_valid <= 1'b1;
    end else if (x_fire) begin
      x_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      x_uop <= uop;
      x_a   <= rd1;
      x_b   <= rd2;
    end
  end

  // alu
  assign prod = x_a * x_b;

  always_comb begin
    unique case (x_uop.opc)
      eci_pkg::OPC_ADD: alu_val = x_a + x_b;
      eci_pkg::OPC_SUB: alu_val = x_a - x_b;
      eci_pkg::OPC_MUL: alu_val = prod[7:0];
      eci_pkg::OPC_INC: alu_val = x_b + 8'd1;
      eci_pkg::OPC_AND: alu_val = x_a & x_b;
      eci_pkg::OPC_OR:  alu_val = x_a | x_b;
      eci_pkg::OPC_NOT: alu_val = ~x_a;
      eci_pkg::OPC_XOR: alu_val = x_a ^ x_b;
      default:          alu_val = 8'd0;
    endcase
  end

  // next pc, memory access and status of the item in execute
  assign pc2       = pc + 8'd2;
  assign br_target = pc2 + {x_uop.offset[6:0], 1'b0};
  assign ea        = x_a + {4'd0, x_uop.rc};
  assign x_ra_ok   = ({1'b0, x_uop.ra} < NREG);
  assign mem_ok    = ({1'b0, mem_addr} < NBYTE);

  always_comb begin
    x_npc    = pc;
    x_status = eci_pkg::ST_DONE;
    x_wr     = 1'b0;
    x_load   = 1'b0;
    halt_set = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = ea;
    mem_wd   = x_b;
    if (halted) begin
      x_status = eci_pkg::ST_HALTED;
    end else begin
      unique case (x_uop.kind)
        eci_pkg::K_PRELOAD: begin
          mem_we   = 1'b1;
          mem_addr = x_uop.mem_address;
          mem_wd   = x_uop.mem_value;
        end
        eci_pkg::K_ALU: begin
          x_npc = pc2;
          x_wr  = 1'b1;
        end
        eci_pkg::K_LOAD: begin
          x_npc  = pc2;
          x_load = 1'b1;
          mem_re = 1'b1;
        end
        eci_pkg::K_STORE: begin
          x_npc  = pc2;
          mem_we = 1'b1;
        end
        eci_pkg::K_JMP: begin
          x_npc = br_target;
        end
        eci_pkg::K_BEQZ: begin
          x_npc = (x_b == 8'd0) ? br_target : pc2;
        end
        eci_pkg::K_HLT: begin
          x_npc    = pc2;
          halt_set = 1'b1;
          x_status = eci_pkg::ST_HALTED;
        end
        default: begin
          x_npc    = pc2;
          x_status = eci_pkg::ST_INVALID;
        end
      endcase
    end
  end

  // program counter and halt flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= 8'd0;
      halted <= 1'b0;
    end else if (x_fire) begin
      pc <= x_npc;
      if (halt_set) halted <= 1'b1;
    end
  end

  // data memory, registered read
  always_ff @(posedge clk) begin
    if (x_fire && mem_we && mem_ok) dmem[mem_addr[MIW-1:0]] <= mem_wd;
    if (x_fire && mem_re) begin
      ld_data <= dmem[mem_addr[MIW-1:0]];
      ld_vld  <= mem_ok && dvalid[mem_addr[MIW-1:0]];
    end
  end

  // per-byte written marks, unwritten bytes read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= '0;
    end else if (x_fire && mem_we && mem_ok) begin
      dvalid[mem_addr[MIW-1:0]] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else if (x_fire) begin
      w_valid <= 1'b1;
    end else if (out_fire) begin
      w_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (x_fire) begin
      w_npc    <= x_npc;
      w_wr     <= (x_wr || x_load) && x_ra_ok;
      w_dest   <= x_uop.ra;
      w_val    <= alu_val;
      w_status <= x_status;
      w_load   <= x_load;
    end
  end

  assign w_value = w_load ? (ld_vld ? ld_data : 8'd0) : w_val;

  assign rsp.valid       = w_valid;
  assign rsp.next_pc     = w_npc;
  assign rsp.reg_written = w_wr;
  assign rsp.dest_reg    = w_wr ? w_dest : 4'd0;
  assign rsp.write_value = w_wr ? w_value : 8'd0;
  assign rsp.status      = w_status;

  // register file write: a load commits as its result leaves
  always_comb begin
    if (w_valid && w_load) begin
      rf_we = out_fire && w_wr;
      rf_wa = w_dest;
      rf_wd = w_value;
    end else begin
      rf_we = x_fire && x_wr && x_ra_ok;
      rf_wa = x_uop.ra;
      rf_wd = alu_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= 8'd0;
    end else if (rf_we) begin
      regs[rf_wa[RIW-1:0]] <= rf_wd;
    end
  end

endmodule

`default_nettype wire

/* src/eight_bit_cpu_instruction_executor.sv */
// ----------------------------------------------------------------------------
// eight_bit_cpu_instruction_executor
// In-order executor of a small 8-bit machine: decode front, two-entry queue,
// execute back with register file, data memory, pc and halt flag.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   op, instruction, mem_address, mem_value
//   rsp      out  valid/ready   next_pc, reg_written, dest_reg, write_value,
//                               status
//
// One item per cycle sustained while results are taken; a LOAD holds issue
// until its result leaves, because the data memory read is registered and the
// byte is written to the register file as its result leaves. A result passes
// through the queue, the execute register and the result register.
// Reset clears the registers, pc, halt flag and the written marks of all data
// memory bytes together; there is no clearing pass.
// A stalled result holds the back end; the queue still takes two more items.
// ----------------------------------------------------------------------------
`default_nettype none

module eight_bit_cpu_instruction_executor #(
  parameter int NUM_REGS       = 16,
  parameter int DATA_MEM_BYTES = 256
) (
  input  logic      clk,
  input  logic      rst,
  eci_in_if.sink    req,
  eci_out_if.source rsp
);

  logic          f_valid;
  logic          f_ready;
  eci_pkg::uop_t f_uop;
  logic          q_valid;
  logic          q_ready;
  eci_pkg::uop_t q_uop;

  // decode
  eci_front u_front (
    .req       (req),
    .uop_valid (f_valid),
    .uop_ready (f_ready),
    .uop       (f_uop)
  );

  // decoupling queue
  eci_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_uop   (f_uop),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_uop    (q_uop)
  );

  // execute
  eci_back #(
    .NUM_REGS       (NUM_REGS),
    .DATA_MEM_BYTES (DATA_MEM_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .uop_valid (q_valid),
    .uop_ready (q_ready),
    .uop       (q_uop),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

/* src/eci_checker.sv */
// ----------------------------------------------------------------------------
// eci_checker
// Port-level checks on the result channel of the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module eci_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] next_pc,
  input logic       reg_written,
  input logic [3:0] dest_reg,
  input logic [7:0] write_value,
  input logic [1:0] status
);

  logic rsp_fire;
  logic seen_halt;

  assign rsp_fire = rsp_valid && rsp_ready;

  // a halt result has been delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_halt <= 1'b0;
    end else if (rsp_fire && (status == eci_pkg::ST_HALTED)) begin
      seen_halt <= 1'b1;
    end
  end

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // unused destination fields read zero
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !reg_written) |-> (dest_reg == 4'd0) && (write_value == 8'd0))
    else $error("destination fields nonzero without register write");

  // halted or skipped items write no register
  a_no_write: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status != eci_pkg::ST_DONE)) |-> !reg_written)
    else $error("register write on halted or invalid item");

  // once halted, every later result reports halted
  a_stay_halted: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && seen_halt) |-> (status == eci_pkg::ST_HALTED))
    else $error("result after halt not marked halted");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(next_pc) &&
      $stable(reg_written) && $stable(dest_reg) && $stable(write_value) &&
      $stable(status))
    else $error("stalled result changed");

endmodule

bind eight_bit_cpu_instruction_executor eci_checker u_eci_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .next_pc     (rsp.next_pc),
  .reg_written (rsp.reg_written),
  .dest_reg    (rsp.dest_reg),
  .write_value (rsp.write_value),
  .status      (rsp.status)
);

`default_nettype wire

/* bench/eight_bit_cpu_instruction_executor_tb.sv */
// ----------------------------------------------------------------------------
// eight_bit_cpu_instruction_executor_tb
// Drives instruction and preload items into the executor and checks every
// result against a table row or a cycle-free model of the machine kept in the bench. A short
// directed table runs first, then random instruction streams. The halt table
// rows run last because a halt is only left by reset. Both channel ends idle
// in random bursts, and one long output stall fills the block up.
// ----------------------------------------------------------------------------

module eight_bit_cpu_instruction_executor_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_REGS       = 16;
  localparam int DATA_MEM_BYTES = 256;

  // opcodes with no meaning in the machine
  localparam logic [3:0] OPC_UNDEF_C = 4'd12;
  localparam logic [3:0] OPC_UNDEF_D = 4'd13;
  localparam logic [3:0] OPC_UNDEF_E = 4'd14;

  localparam int N_RANDOM     = 1200;
  localparam int QUIET_ITEMS  = 200;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic [7:0] next_pc;
    logic       reg_written;
    logic [3:0] dest_reg;
    logic [7:0] write_value;
    logic [1:0] status;
  } exec_result_t;

  typedef struct packed {
    logic         op;
    logic [15:0]  instruction;
    logic [7:0]   mem_address;
    logic [7:0]   mem_value;
    logic         typed;
    exec_result_t result;
  } stim_row_t;

  function automatic logic [15:0] instr_word(logic [3:0] opc, logic [3:0] ra,
                                             logic [3:0] rb, logic [3:0] rc);
    return {opc, ra, rb, rc};
  endfunction

  localparam exec_result_t NO_CHECK = '0;
  localparam int HALT_ROW = 25;
  localparam int N_DIR    = 29;

  // directed items; rows from HALT_ROW on run after the random part
  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    // after reset every register reads zero
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_ADD, 4'd1, 4'd0, 4'd0), 8'h00, 8'h00, 1'b1,
      '{8'd2, 1'b1, 4'd1, 8'h00, eci_pkg::ST_DONE}},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_INC, 4'd1, 4'd0, 4'd0), 8'h00, 8'h00, 1'b1,
      '{8'd4, 1'b1, 4'd1, 8'h01, eci_pkg::ST_DONE}},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_NOT, 4'd2, 4'd0, 4'd0), 8'h00, 8'h00, 1'b1,
      '{8'd6, 1'b1, 4'd2, 8'hff, eci_pkg::ST_DONE}},
    // increment wraps to zero
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_INC, 4'd2, 4'd0, 4'd0), 8'h00, 8'h00, 1'b1,
      '{8'd8, 1'b1, 4'd2, 8'h00, eci_pkg::ST_DONE}},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_NOT, 4'd15, 4'd0, 4'd0), 8'h00, 8'h00, 1'b1,
      '{8'd10, 1'b1, 4'd15, 8'hff, eci_pkg::ST_DONE}},
    // preloads leave the pc alone
    '{eci_pkg::ITEM_PRELOAD, 16'h0000, 8'hff, 8'hff, 1'b1,
      '{8'd10, 1'b0, 4'd0, 8'h00, eci_pkg::ST_DONE}},
    '{eci_pkg::ITEM_PRELOAD, 16'hffff, 8'h00, 8'ha5, 1'b1,
      '{8'd10, 1'b0, 4'd0, 8'h00, eci_pkg::ST_DONE}},
    '{eci_pkg::ITEM_PRELOAD, 16'h5a5a, 8'h80, 8'h00, 1'b1,
      '{8'd10, 1'b0, 4'd0, 8'h00, eci_pkg::ST_DONE}},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_LOAD, 4'd3, 4'd15, 4'd0), 8'h00, 8'h00, 1'b1,
      '{8'd12, 1'b1, 4'd3, 8'hff, eci_pkg::ST_DONE}},
    // effective address wraps past the top of memory
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_LOAD, 4'd4, 4'd15, 4'd1), 8'h00, 8'h00, 1'b1,
      '{8'd14, 1'b1, 4'd4, 8'ha5, eci_pkg::ST_DONE}},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_ADD, 4'd5, 4'd15, 4'd1), 8'h00, 8'h00, 1'b0,
      NO_CHECK},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_SUB, 4'd6, 4'd0, 4'd1), 8'h00, 8'h00, 1'b0,
      NO_CHECK},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_MUL, 4'd7, 4'd15, 4'd15), 8'h00, 8'h00, 1'b0,
      NO_CHECK},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_AND, 4'd8, 4'd15, 4'd4), 8'h00, 8'h00, 1'b0,
      NO_CHECK},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_OR, 4'd9, 4'd4, 4'd1), 8'h00, 8'h00, 1'b0,
      NO_CHECK},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_XOR, 4'd10, 4'd15, 4'd4), 8'h00, 8'h00, 1'b0,
      NO_CHECK},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_STORE, 4'd4, 4'd15, 4'd15), 8'h00, 8'h00,
      1'b0, NO_CHECK},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_LOAD, 4'd11, 4'd0, 4'd14), 8'h00, 8'h00,
      1'b0, NO_CHECK},
    // unknown opcodes only move the pc
    '{eci_pkg::ITEM_EXEC, instr_word(OPC_UNDEF_C, 4'd1, 4'd2, 4'd3), 8'h00, 8'h00, 1'b1,
      '{8'd32, 1'b0, 4'd0, 8'h00, eci_pkg::ST_INVALID}},
    '{eci_pkg::ITEM_EXEC, instr_word(OPC_UNDEF_D, 4'd4, 4'd5, 4'd6), 8'h00, 8'h00, 1'b1,
      '{8'd34, 1'b0, 4'd0, 8'h00, eci_pkg::ST_INVALID}},
    '{eci_pkg::ITEM_EXEC, instr_word(OPC_UNDEF_E, 4'd15, 4'd15, 4'd15), 8'h00, 8'h00, 1'b1,
      '{8'd36, 1'b0, 4'd0, 8'h00, eci_pkg::ST_INVALID}},
    // jumps to both offset extremes, branch taken and not taken
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_JMP, 4'h7, 4'hf, 4'h0), 8'h00, 8'h00, 1'b0,
      NO_CHECK},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_JMP, 4'h8, 4'h0, 4'h0), 8'h00, 8'h00, 1'b0,
      NO_CHECK},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_BEQZ, 4'h0, 4'hf, 4'hf), 8'h00, 8'h00, 1'b0,
      NO_CHECK},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_BEQZ, 4'hf, 4'h8, 4'h0), 8'h00, 8'h00, 1'b0,
      NO_CHECK},
    // halt, then items that are ignored
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_HLT, 4'd0, 4'd0, 4'd0), 8'h00, 8'h00, 1'b0,
      NO_CHECK},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_ADD, 4'd1, 4'd2, 4'd3), 8'h12, 8'h34, 1'b0,
      NO_CHECK},
    '{eci_pkg::ITEM_PRELOAD, 16'h0000, 8'h40, 8'h77, 1'b0, NO_CHECK},
    '{eci_pkg::ITEM_EXEC, instr_word(eci_pkg::OPC_HLT, 4'hf, 4'hf, 4'hf), 8'hff, 8'hff, 1'b0,
      NO_CHECK}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  eci_in_if  req_ch ();
  eci_out_if rsp_ch ();

  eight_bit_cpu_instruction_executor #(
    .NUM_REGS      (NUM_REGS),
    .DATA_MEM_BYTES(DATA_MEM_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // machine state as the bench sees it
  logic [7:0] cpu_regs [16];
  logic [7:0] cpu_mem  [256];
  logic [7:0] cpu_pc;
  logic       cpu_halted;

  exec_result_t pending_results [$];
  int  fail_count    = 0;
  int  cycle_count   = 0;
  bit  quiet         = 1'b0;
  bit  long_hold_req = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] reg_rd(logic [3:0] n);
    return (n < NUM_REGS) ? cpu_regs[n] : 8'h00;
  endfunction

  // one item through the machine, returns the result it causes
  function automatic exec_result_t run_machine(logic op, logic [15:0] word,
                                               logic [7:0] addr, logic [7:0] data);
    exec_result_t r;
    logic [3:0] opc, ra, rb, rc;
    logic [7:0] a, b, v, pc2, ea;
    logic       wr;
    opc = word[15:12];
    ra  = word[11:8];
    rb  = word[7:4];
    rc  = word[3:0];
    r   = '0;
    wr  = 1'b0;
    v   = 8'h00;
    if (cpu_halted) begin
      r.status = eci_pkg::ST_HALTED;
    end else if (op == eci_pkg::ITEM_PRELOAD) begin
      if (addr < DATA_MEM_BYTES) cpu_mem[addr] = data;
    end else begin
      pc2 = cpu_pc + 8'd2;
      a = reg_rd(rb);
      b = reg_rd(rc);
      ea = a + {4'h0, rc};
      cpu_pc = pc2;
      case (opc)
        eci_pkg::OPC_ADD: begin wr = 1'b1; v = a + b; end
        eci_pkg::OPC_SUB: begin wr = 1'b1; v = a - b; end
        eci_pkg::OPC_MUL: begin wr = 1'b1; v = a * b; end
        eci_pkg::OPC_INC: begin wr = 1'b1; v = reg_rd(ra) + 8'd1; end
        eci_pkg::OPC_AND: begin wr = 1'b1; v = a & b; end
        eci_pkg::OPC_OR:  begin wr = 1'b1; v = a | b; end
        eci_pkg::OPC_NOT: begin wr = 1'b1; v = ~a; end
        eci_pkg::OPC_XOR: begin wr = 1'b1; v = a ^ b; end
        eci_pkg::OPC_LOAD: begin
          wr = 1'b1;
          v = (ea < DATA_MEM_BYTES) ? cpu_mem[ea] : 8'h00;
        end
        eci_pkg::OPC_STORE: begin
          if (ea < DATA_MEM_BYTES) cpu_mem[ea] = reg_rd(ra);
        end
        eci_pkg::OPC_JMP:  cpu_pc = pc2 + {word[10:4], 1'b0};
        eci_pkg::OPC_BEQZ: begin
          if (reg_rd(ra) == 8'h00) cpu_pc = pc2 + {word[6:0], 1'b0};
        end
        eci_pkg::OPC_HLT: begin
          cpu_halted = 1'b1;
          r.status = eci_pkg::ST_HALTED;
        end
        default: r.status = eci_pkg::ST_INVALID;
      endcase
      if (wr && ra < NUM_REGS) cpu_regs[ra] = v;
      else wr = 1'b0;
    end
    r.next_pc     = cpu_pc;
    r.reg_written = wr;
    r.dest_reg    = wr ? ra : 4'd0;
    r.write_value = wr ? v : 8'h00;
    return r;
  endfunction

  // present one item and hold it until it is taken
  task automatic offer_item(input logic op, input logic [15:0] word,
                            input logic [7:0] addr, input logic [7:0] data,
                            input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.instruction <= word;
    req_ch.mem_address <= addr;
    req_ch.mem_value   <= data;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  task automatic send_row(input int idx);
    stim_row_t    row;
    exec_result_t pred;
    row = DIR_ROWS[idx];
    offer_item(row.op, row.instruction, row.mem_address, row.mem_value, !quiet);
    pred = run_machine(row.op, row.instruction, row.mem_address, row.mem_value);
    pending_results.push_back(row.typed ? row.result : pred);
  endtask

  task automatic field_check(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // stimulus
  initial begin
    int           k;
    logic         op;
    logic [15:0]  word;
    logic [7:0]   addr, data;
    exec_result_t pred;
    for (int i = 0; i < 16; i++) cpu_regs[i] = 8'h00;
    for (int i = 0; i < 256; i++) cpu_mem[i] = 8'h00;
    cpu_pc     = 8'h00;
    cpu_halted = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.op          = eci_pkg::ITEM_EXEC;
    req_ch.instruction = '0;
    req_ch.mem_address = '0;
    req_ch.mem_value   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < HALT_ROW; k++) send_row(k);

    // random streams of every opcode but halt, with preloads mixed in
    for (k = 0; k < N_RANDOM; k++) begin
      if (k == LONG_HOLD_AT) long_hold_req = 1'b1;
      if (k == N_RANDOM - QUIET_ITEMS) quiet = 1'b1;
      op   = ($urandom_range(0, 5) == 0) ? eci_pkg::ITEM_PRELOAD : eci_pkg::ITEM_EXEC;
      word = {4'($urandom_range(0, 14)), 12'($urandom)};
      addr = 8'($urandom);
      data = 8'($urandom);
      offer_item(op, word, addr, data, !quiet && ((k / 40) % 3 != 2));
      pred = run_machine(op, word, addr, data);
      pending_results.push_back(pred);
    end

    for (k = HALT_ROW; k < N_DIR; k++) send_row(k);
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result side back-pressure, random bursts plus one long hold
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    rsp_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_req) begin
        hold_cnt = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (hold_cnt == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        hold_cnt = $urandom_range(1, 9);
      end
      if (hold_cnt > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_cnt--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    exec_result_t got, want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got = '{rsp_ch.next_pc, rsp_ch.reg_written, rsp_ch.dest_reg,
              rsp_ch.write_value, rsp_ch.status};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        field_check("next_pc", want.next_pc, got.next_pc);
        field_check("reg_written", 8'(want.reg_written), 8'(got.reg_written));
        field_check("dest_reg", 8'(want.dest_reg), 8'(got.dest_reg));
        field_check("write_value", want.write_value, got.write_value);
        field_check("status", 8'(want.status), 8'(got.status));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

endmodule

/* eight_bit_cpu_instruction_executor.f */
src/eci_pkg.sv
src/eci_in_if.sv
src/eci_out_if.sv
src/eci_front.sv
src/eci_queue.sv
src/eci_back.sv
src/eight_bit_cpu_instruction_executor.sv
src/eci_checker.sv
bench/eight_bit_cpu_instruction_executor_tb.sv
